// ----- design/lcdn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_pkg
// Shared types, codes, tables and helpers of the 4-bit character LCD driver.
// ----------------------------------------------------------------------------
package lcdn_pkg;

    // request op codes
    localparam logic [2:0] OP_CMD    = 3'd0;
    localparam logic [2:0] OP_CHAR   = 3'd1;
    localparam logic [2:0] OP_CURSOR = 3'd2;
    localparam logic [2:0] OP_INIT   = 3'd3;
    localparam logic [2:0] OP_CYR    = 3'd4;
    localparam logic [2:0] OP_LIGHT  = 3'd5;

    localparam logic [15:0] DELAY_RESET = 16'd1000;

    // cursor address build
    localparam logic [7:0] CURSOR_BASE    = 8'h80;
    localparam logic [7:0] CURSOR_ROW2    = 8'h40;
    localparam logic [1:0] CURSOR_ROW_SEL = 2'd2;
    localparam logic [4:0] CURSOR_COLS    = 5'd16;

    // hold time multiples of the delay register
    localparam logic [1:0] MULT_ZERO = 2'd0;
    localparam logic [1:0] MULT_ONE  = 2'd1;
    localparam logic [1:0] MULT_TWO  = 2'd2;

    // power-up sequence shape
    localparam logic [3:0] RAW_NIB        = 4'h3;
    localparam logic [3:0] RAW_NIB_LAST   = 4'h2;
    localparam logic [2:0] RAW_UNIT_LAST  = 3'd3;
    localparam logic [2:0] RAW_PHASE_LAST = 3'd2;
    localparam logic [2:0] INIT_CMD_LAST  = 3'd4;
    localparam logic [2:0] BYTE_PHASE_LAST = 3'd4;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        JOB_BYTE  = 2'd0,
        JOB_INIT  = 2'd1,
        JOB_LIGHT = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind  kind;
        logic       rs;
        logic [7:0] data;
    } t_job;

    typedef struct packed {
        logic        rs;
        logic        en;
        logic [3:0]  nibble;
        logic        backlight;
        logic [16:0] hold_cycles;
        logic        last;
    } t_pin;

    localparam logic [7:0] CYR_GLYPH [64] = '{
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
    };

    function automatic logic [7:0] init_cmd(input logic [2:0] unit);
        logic [7:0] cmd;
        case (unit)
            3'd0:    cmd = 8'h28;
            3'd1:    cmd = 8'h08;
            3'd2:    cmd = 8'h01;
            3'd3:    cmd = 8'h03;
            3'd4:    cmd = 8'h0C;
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

    function automatic logic [16:0] hold_of(input logic [15:0] d, input logic [1:0] mult);
        logic [16:0] h;
        case (mult)
            MULT_ONE: h = {1'b0, d};
            MULT_TWO: h = {d, 1'b0};
            default:  h = 17'd0;
        endcase
        return h;
    endfunction

endpackage

// ----- design/lcdn_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_req_if
// Request channel: op code, byte value and cursor position.
// ----------------------------------------------------------------------------
interface lcdn_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] value;
    logic [1:0] row;
    logic [4:0] col;

    modport source (output valid, op, value, row, col, input ready);
    modport sink (input valid, op, value, row, col, output ready);
endinterface

// ----- design/lcdn_pin_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_pin_if
// Pin state channel: one timed state of the LCD bus per transaction.
// ----------------------------------------------------------------------------
interface lcdn_pin_if;
    logic        valid;
    logic        ready;
    logic        rs;
    logic        en;
    logic [3:0]  nibble;
    logic        backlight;
    logic [16:0] hold_cycles;
    logic        last;

    modport source (output valid, rs, en, nibble, backlight, hold_cycles, last,
                    input ready);
    modport sink (input valid, rs, en, nibble, backlight, hold_cycles, last,
                  output ready);
endinterface

// ----- design/lcdn_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_front
// Accepts requests and turns them into jobs: a byte with its rs level, the
// power-up sequence, or a backlight update. Unknown ops are dropped.
// ----------------------------------------------------------------------------
module lcdn_front
    import lcdn_pkg::*;
(
    lcdn_req_if.sink i_req,
    input  logic     i_full,
    output logic     o_push,
    output t_job     o_job
);

    logic [7:0] w_pos;

    assign i_req.ready = !i_full;

    always_comb begin
        w_pos = CURSOR_BASE;
        if (i_req.row == CURSOR_ROW_SEL) begin
            w_pos = w_pos | CURSOR_ROW2;
        end
        if (i_req.col < CURSOR_COLS) begin
            w_pos = w_pos | {3'b000, i_req.col};
        end
    end

    always_comb begin
        o_job.kind = JOB_BYTE;
        o_job.rs   = 1'b0;
        o_job.data = i_req.value;
        o_push     = i_req.valid && !i_full;
        unique case (i_req.op)
            OP_CMD: begin
            end
            OP_CHAR: begin
                o_job.rs = 1'b1;
            end
            OP_CURSOR: begin
                o_job.data = w_pos;
            end
            OP_INIT: begin
                o_job.kind = JOB_INIT;
            end
            OP_CYR: begin
                o_job.rs   = 1'b1;
                o_job.data = CYR_GLYPH[i_req.value[5:0]];
            end
            OP_LIGHT: begin
                o_job.kind = JOB_LIGHT;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/lcdn_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_fifo
// Short job queue between the request front and the pin sequencer.
// ----------------------------------------------------------------------------
module lcdn_fifo
    import lcdn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_pop_data,
    output logic o_empty
);

    t_job                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;
    logic                 w_wr;
    logic                 w_rd;

    assign o_full     = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign w_wr       = i_push && !o_full;
    assign w_rd       = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/lcdn_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_back
// Pin sequencer: expands one job into timed bus states, one per cycle while
// o_pin is ready, through a registered output stage. Holds the backlight level.
// ----------------------------------------------------------------------------
module lcdn_back
    import lcdn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_delay,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    lcdn_pin_if.source  o_pin
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WAKE = 4'b0010,
        ST_RAW  = 4'b0100,
        ST_BYTE = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_phase, n_phase;
    logic [2:0]  r_unit, n_unit;
    logic [7:0]  r_byte, n_byte;
    logic        r_rs, n_rs;
    logic        r_init, n_init;
    logic        r_backlight, n_backlight;
    logic        r_out_valid;
    t_pin        r_out;

    logic        w_adv;
    logic        w_emit;
    t_pin        w_pin;
    logic [1:0]  w_mult;
    logic [7:0]  w_cur;

    assign w_adv = !r_out_valid || o_pin.ready;
    assign o_pop = (r_state == ST_IDLE) && !i_empty;
    assign w_cur = r_init ? init_cmd(r_unit) : r_byte;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_unit      = r_unit;
        n_byte      = r_byte;
        n_rs        = r_rs;
        n_init      = r_init;
        n_backlight = r_backlight;
        w_emit      = 1'b0;
        w_mult      = MULT_ZERO;
        w_pin       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    case (i_job.kind)
                        JOB_LIGHT: begin
                            n_backlight = i_job.data[0];
                        end
                        JOB_INIT: begin
                            n_backlight = 1'b1;
                            n_rs        = 1'b0;
                            n_init      = 1'b1;
                            n_state     = ST_WAKE;
                        end
                        default: begin
                            n_byte  = i_job.data;
                            n_rs    = i_job.rs;
                            n_init  = 1'b0;
                            n_phase = '0;
                            n_state = ST_BYTE;
                        end
                    endcase
                end
            end
            ST_WAKE: begin
                // all bus pins low but the backlight, which is on, held one unit
                w_mult = MULT_ONE;
                if (w_adv) begin
                    w_emit  = 1'b1;
                    n_phase = '0;
                    n_unit  = '0;
                    n_state = ST_RAW;
                end
            end
            ST_RAW: begin
                w_pin.nibble = (r_unit == RAW_UNIT_LAST) ? RAW_NIB_LAST : RAW_NIB;
                w_pin.en     = (r_phase == 3'd1);
                w_mult       = (r_phase == 3'd0) ? MULT_ZERO : MULT_ONE;
                if (w_adv) begin
                    w_emit = 1'b1;
                    if (r_phase == RAW_PHASE_LAST) begin
                        n_phase = '0;
                        if (r_unit == RAW_UNIT_LAST) begin
                            n_unit  = '0;
                            n_state = ST_BYTE;
                        end else begin
                            n_unit = r_unit + 1'b1;
                        end
                    end else begin
                        n_phase = r_phase + 1'b1;
                    end
                end
            end
            ST_BYTE: begin
                // high nibble on phases 0-1, low nibble on 2-4, strobe on odd phases
                w_pin.rs     = r_rs;
                w_pin.nibble = (r_phase < 3'd2) ? w_cur[7:4] : w_cur[3:0];
                w_pin.en     = r_phase[0];
                if (r_phase == BYTE_PHASE_LAST) begin
                    w_mult     = r_init ? MULT_TWO : MULT_ONE;
                    w_pin.last = !r_init || (r_unit == INIT_CMD_LAST);
                end else begin
                    w_mult = r_phase[0] ? MULT_ONE : MULT_ZERO;
                end
                if (w_adv) begin
                    w_emit = 1'b1;
                    if (r_phase == BYTE_PHASE_LAST) begin
                        n_phase = '0;
                        if (w_pin.last) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_unit = r_unit + 1'b1;
                        end
                    end else begin
                        n_phase = r_phase + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        w_pin.backlight   = r_backlight;
        w_pin.hold_cycles = hold_of(i_delay, w_mult);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_unit      <= '0;
            r_init      <= 1'b0;
            r_backlight <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_unit      <= n_unit;
            r_init      <= n_init;
            r_backlight <= n_backlight;
            if (w_adv) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_rs   <= n_rs;
        if (w_adv && w_emit) begin
            r_out <= w_pin;
        end
    end

    assign o_pin.valid       = r_out_valid;
    assign o_pin.rs          = r_out.rs;
    assign o_pin.en          = r_out.en;
    assign o_pin.nibble      = r_out.nibble;
    assign o_pin.backlight   = r_out.backlight;
    assign o_pin.hold_cycles = r_out.hold_cycles;
    assign o_pin.last        = r_out.last;

endmodule

// ----- design/char_lcd_nibble_interface_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_top
// Character LCD driver for a 4-bit bus: turns requests into timed pin states.
// ----------------------------------------------------------------------------
// Usage:
//   i_req  carries one request per transaction (op, value, row, col).
//   o_pin  carries one pin state per transaction: rs, en, nibble, backlight,
//          the hold time in cycles and a last flag on the final state.
//   i_cfg_we / i_cfg_data write the delay unit; change it only while idle.
// Timing:
//   a request enters a two-entry job queue at acceptance; the sequencer pops
//   it when idle, and its first pin state is then registered in the output
//   stage. a byte gives five pin states, the power-up sequence 38 and a
//   backlight update none; the single sequencer takes one job at a time
//   and outputs one state per cycle while o_pin is ready.
// Reset:
//   queue empties, output valid drops, backlight off, delay unit 1000.
// Stall:
//   a stalled o_pin holds its state; the sequencer waits, the queue fills
//   and i_req.ready drops once two jobs are waiting.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface_top
    import lcdn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcdn_req_if.sink    i_req,
    lcdn_pin_if.source  o_pin,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_delay;
    logic        w_push;
    logic        w_full;
    logic        w_pop;
    logic        w_empty;
    t_job        w_push_job;
    t_job        w_pop_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
        end else if (i_cfg_we) begin
            r_delay <= i_cfg_data;
        end
    end

    lcdn_front u_front (
        .i_req  (i_req),
        .i_full (w_full),
        .o_push (w_push),
        .o_job  (w_push_job)
    );

    lcdn_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_job),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_job),
        .o_empty     (w_empty)
    );

    lcdn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_delay (r_delay),
        .i_empty (w_empty),
        .i_job   (w_pop_job),
        .o_pop   (w_pop),
        .o_pin   (o_pin)
    );

    // no job is pushed into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into full queue");

    // a strobe state is held exactly one delay unit
    a_strobe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pin.valid && o_pin.en) |-> (o_pin.hold_cycles == {1'b0, r_delay}))
        else $error("strobe hold differs from delay unit");

    // a request always ends with the strobe released
    a_last_en_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pin.valid && o_pin.last) |-> !o_pin.en)
        else $error("final state has enable high");

    // output is empty right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pin.valid)
        else $error("output valid after reset");

endmodule
